>>> rtl/imu_frame_parser_crc16_unit_defines.svh
// Assertion macros shared by the checker of the IMU frame parser.
`ifndef IMU_FRAME_PARSER_CRC16_UNIT_DEFINES_SVH
`define IMU_FRAME_PARSER_CRC16_UNIT_DEFINES_SVH

// Clocked assertion, disabled while reset is held.
`define IMUFP_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked implication, same reset handling.
`define IMUFP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/imufp_pkg.sv
// Types, constants and helper functions of the IMU frame parser.
package imufp_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 255;
  localparam int unsigned NUM_FIELDS      = 6;

  localparam logic [7:0]  SYNC0 = 8'h5A;
  localparam logic [7:0]  SYNC1 = 8'hA5;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Item tags
  localparam logic [7:0] TAG_USER_ID     = 8'h90;
  localparam logic [7:0] TAG_ACCEL       = 8'hA0;
  localparam logic [7:0] TAG_ACCEL_LIN   = 8'hA5;
  localparam logic [7:0] TAG_GYRO        = 8'hB0;
  localparam logic [7:0] TAG_MAG         = 8'hC0;
  localparam logic [7:0] TAG_EULER       = 8'hD0;
  localparam logic [7:0] TAG_EULER_FLOAT = 8'hD9;
  localparam logic [7:0] TAG_QUAT        = 8'hD1;
  localparam logic [7:0] TAG_PRESSURE    = 8'hF0;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_FRAME = 2'd1;
  localparam logic [1:0] ST_BAD_CRC   = 2'd2;

  // Configuration register indexes
  localparam logic REG_ROLL_OFFSET    = 1'b0;
  localparam logic REG_WRAP_THRESHOLD = 1'b1;

  localparam logic [15:0] ROLL_OFFSET_RST    = 16'd467;
  localparam logic [11:0] WRAP_THRESHOLD_RST = 12'd3300;

  // Field slots: gyro X, Y, Z, then pitch, roll, yaw
  localparam logic [2:0] F_RATE_X = 3'd0;
  localparam logic [2:0] F_RATE_Y = 3'd1;
  localparam logic [2:0] F_RATE_Z = 3'd2;
  localparam logic [2:0] F_PITCH  = 3'd3;
  localparam logic [2:0] F_ROLL   = 3'd4;
  localparam logic [2:0] F_YAW    = 3'd5;

  localparam logic signed [27:0] YAW_TURN_TENTHS = 28'sd3600;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] rate_x;
    logic [15:0] rate_y;
    logic [15:0] rate_z;
    logic [15:0] pitch;
    logic [15:0] roll;
    logic [15:0] yaw;
  } frame_res_t;

  function automatic logic [4:0] item_length(input logic [7:0] tag);
    logic [4:0] n;
    case (tag)
      TAG_USER_ID:     n = 5'd1;
      TAG_ACCEL:       n = 5'd6;
      TAG_ACCEL_LIN:   n = 5'd6;
      TAG_GYRO:        n = 5'd6;
      TAG_MAG:         n = 5'd6;
      TAG_EULER:       n = 5'd6;
      TAG_EULER_FLOAT: n = 5'd12;
      TAG_QUAT:        n = 5'd16;
      TAG_PRESSURE:    n = 5'd4;
      default:         n = 5'd0;
    endcase
    return n;
  endfunction

  // One byte of CRC-16, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (x[15]) begin
        x = {x[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        x = {x[14:0], 1'b0};
      end
    end
    return x;
  endfunction

endpackage

>>> rtl/imufp_frame.sv
// Frame tracker: header and length check, CRC, item parsing, shadow and commit registers.
module imufp_frame #(
  parameter int unsigned MAX_FRAME_BYTES = imufp_pkg::MAX_FRAME_BYTES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   byte_valid,
  input  logic [7:0]             byte_data,
  input  logic                   byte_last,
  output logic                   res_valid,
  output imufp_pkg::frame_res_t  res
);

  localparam int unsigned PW = $clog2(MAX_FRAME_BYTES + 1);

  logic [PW-1:0] pos_r,  pos_nxt;
  logic [15:0]   crc_r,  crc_nxt;
  logic [15:0]   decl_r, decl_nxt;
  logic [15:0]   rcrc_r, rcrc_nxt;
  logic          hg_r,   hg_nxt;
  logic [7:0]    tag_r,  tag_nxt;
  logic [4:0]    left_r, left_nxt;
  logic          stop_r, stop_nxt;
  logic [7:0]    low_r,  low_nxt;
  logic [15:0]   shadow_r [imufp_pkg::NUM_FIELDS];
  logic [15:0]   shadow_nxt [imufp_pkg::NUM_FIELDS];
  logic [15:0]   commit_r [imufp_pkg::NUM_FIELDS];
  logic [15:0]   commit_nxt [imufp_pkg::NUM_FIELDS];

  logic [4:0]    item_len;
  logic [4:0]    k;
  logic [2:0]    idx;
  logic          good;
  logic [1:0]    status;

  always_comb begin
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    decl_nxt = decl_r;
    rcrc_nxt = rcrc_r;
    hg_nxt   = hg_r;
    tag_nxt  = tag_r;
    left_nxt = left_r;
    stop_nxt = stop_r;
    low_nxt  = low_r;
    shadow_nxt = shadow_r;
    commit_nxt = commit_r;
    item_len = imufp_pkg::item_length(byte_data);
    k        = imufp_pkg::item_length(tag_r) - left_r;
    idx      = k[3:1] + ((tag_r == imufp_pkg::TAG_EULER) ? 3'd3 : 3'd0);
    good     = 1'b0;
    status   = imufp_pkg::ST_OK;

    if (byte_valid) begin
      if (pos_r >= PW'(MAX_FRAME_BYTES)) begin
        // overlong: drop the word, fail the frame
        hg_nxt = 1'b0;
      end else begin
        if (pos_r == PW'(0)) begin
          shadow_nxt = commit_r;
          if (byte_data != imufp_pkg::SYNC0) hg_nxt = 1'b0;
        end
        if (pos_r == PW'(1) && byte_data != imufp_pkg::SYNC1) hg_nxt = 1'b0;
        if (pos_r == PW'(2)) decl_nxt[7:0]  = byte_data;
        if (pos_r == PW'(3)) decl_nxt[15:8] = byte_data;
        if (pos_r == PW'(4)) rcrc_nxt[7:0]  = byte_data;
        if (pos_r == PW'(5)) rcrc_nxt[15:8] = byte_data;
        if (pos_r != PW'(4) && pos_r != PW'(5)) begin
          crc_nxt = imufp_pkg::crc16_byte(crc_r, byte_data);
        end
        if (pos_r >= PW'(6) && !stop_r) begin
          if (left_r == 5'd0) begin
            if (item_len == 5'd0) begin
              stop_nxt = 1'b1;
            end else begin
              tag_nxt  = byte_data;
              left_nxt = item_len;
            end
          end else begin
            if (tag_r == imufp_pkg::TAG_GYRO || tag_r == imufp_pkg::TAG_EULER) begin
              if (!k[0]) begin
                low_nxt = byte_data;
              end else if (idx < 3'(imufp_pkg::NUM_FIELDS)) begin
                shadow_nxt[idx] = {byte_data, low_r};
              end
            end
            left_nxt = left_r - 5'd1;
          end
        end
        pos_nxt = pos_r + PW'(1);
      end

      if (byte_last) begin
        good = hg_nxt && (pos_nxt >= PW'(8)) &&
               ({1'b0, decl_nxt} + 17'd6 == 17'(pos_nxt));
        if (!good) begin
          status = imufp_pkg::ST_BAD_FRAME;
        end else if (crc_nxt != rcrc_nxt) begin
          status = imufp_pkg::ST_BAD_CRC;
        end else begin
          status     = imufp_pkg::ST_OK;
          commit_nxt = shadow_nxt;
        end
        pos_nxt  = '0;
        crc_nxt  = '0;
        decl_nxt = '0;
        rcrc_nxt = '0;
        hg_nxt   = 1'b1;
        tag_nxt  = '0;
        left_nxt = '0;
        stop_nxt = 1'b0;
        low_nxt  = '0;
      end
    end
  end

  assign res_valid   = byte_valid && byte_last;
  assign res.status  = status;
  assign res.rate_x  = commit_nxt[imufp_pkg::F_RATE_X];
  assign res.rate_y  = commit_nxt[imufp_pkg::F_RATE_Y];
  assign res.rate_z  = commit_nxt[imufp_pkg::F_RATE_Z];
  assign res.pitch   = commit_nxt[imufp_pkg::F_PITCH];
  assign res.roll    = commit_nxt[imufp_pkg::F_ROLL];
  assign res.yaw     = commit_nxt[imufp_pkg::F_YAW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      crc_r  <= '0;
      decl_r <= '0;
      rcrc_r <= '0;
      hg_r   <= 1'b1;
      tag_r  <= '0;
      left_r <= '0;
      stop_r <= 1'b0;
      low_r  <= '0;
      for (int i = 0; i < imufp_pkg::NUM_FIELDS; i++) begin
        shadow_r[i] <= '0;
        commit_r[i] <= '0;
      end
    end else begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      decl_r   <= decl_nxt;
      rcrc_r   <= rcrc_nxt;
      hg_r     <= hg_nxt;
      tag_r    <= tag_nxt;
      left_r   <= left_nxt;
      stop_r   <= stop_nxt;
      low_r    <= low_nxt;
      shadow_r <= shadow_nxt;
      commit_r <= commit_nxt;
    end
  end

endmodule

>>> rtl/imufp_emit.sv
// Result stage: holding register, yaw unwrapping, sign flips, roll offset and output register.
module imufp_emit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  res_valid,
  input  imufp_pkg::frame_res_t res,
  output logic                  res_ready,
  input  logic [15:0]           roll_offset,
  input  logic [11:0]           wrap_threshold,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic signed [16:0]    out_yaw_rate,
  output logic signed [16:0]    out_pitch_rate,
  output logic signed [16:0]    out_roll_rate,
  output logic signed [27:0]    out_yaw_att,
  output logic signed [15:0]    out_pitch_att,
  output logic signed [16:0]    out_roll_att
);

  logic                  hold_valid_r;
  imufp_pkg::frame_res_t hold_r;

  logic                  out_valid_r;
  logic [1:0]            status_r;
  logic signed [16:0]    yaw_rate_r, pitch_rate_r, roll_rate_r, roll_att_r;
  logic signed [27:0]    yaw_att_r;
  logic signed [15:0]    pitch_att_r;

  logic signed [16:0]    prev_yaw_r;
  logic signed [15:0]    turns_r, turns_nxt;

  logic                  out_load;
  logic signed [16:0]    yaw_neg;
  logic signed [17:0]    delta;
  logic signed [17:0]    thr;
  logic signed [27:0]    turns_ext;
  logic signed [27:0]    yaw_att_nxt;

  assign out_load  = hold_valid_r && (!out_valid_r || out_ready);
  assign res_ready = !hold_valid_r || out_load;

  always_comb begin
    yaw_neg   = 17'sd0 - {hold_r.yaw[15], hold_r.yaw};
    delta     = {yaw_neg[16], yaw_neg} - {prev_yaw_r[16], prev_yaw_r};
    thr       = {6'b0, wrap_threshold};
    turns_nxt = turns_r;
    if (delta >= thr) begin
      if (turns_r != 16'sh8000) turns_nxt = turns_r - 16'sd1;
    end else if (delta <= -thr) begin
      if (turns_r != 16'sh7FFF) turns_nxt = turns_r + 16'sd1;
    end
    turns_ext   = {{12{turns_nxt[15]}}, turns_nxt};
    yaw_att_nxt = {{11{yaw_neg[16]}}, yaw_neg} + turns_ext * imufp_pkg::YAW_TURN_TENTHS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      prev_yaw_r   <= '0;
      turns_r      <= '0;
    end else begin
      if (res_ready) hold_valid_r <= res_valid;
      if (out_load) begin
        out_valid_r <= 1'b1;
        prev_yaw_r  <= yaw_neg;
        turns_r     <= turns_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) hold_r <= res;
    if (out_load) begin
      status_r     <= hold_r.status;
      yaw_rate_r   <= 17'sd0 - {hold_r.rate_z[15], hold_r.rate_z};
      pitch_rate_r <= 17'sd0 - {hold_r.rate_y[15], hold_r.rate_y};
      roll_rate_r  <= 17'sd0 - {hold_r.rate_x[15], hold_r.rate_x};
      yaw_att_r    <= yaw_att_nxt;
      pitch_att_r  <= hold_r.pitch;
      roll_att_r   <= {hold_r.roll[15], hold_r.roll} + {roll_offset[15], roll_offset};
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_yaw_rate   = yaw_rate_r;
  assign out_pitch_rate = pitch_rate_r;
  assign out_roll_rate  = roll_rate_r;
  assign out_yaw_att    = yaw_att_r;
  assign out_pitch_att  = pitch_att_r;
  assign out_roll_att   = roll_att_r;

endmodule

>>> rtl/imu_frame_parser_crc16_unit.sv
// Words pass the input register, frame tracker, holding and output registers; these overlap.
// Throughput: one word per cycle, unless a frame's last word waits for result-stage room.
// Only the last word of a frame yields a result; the result stage holds one and outputs one.
// Reset (rst_n low, synchronous) clears frame state, shadow and committed fields, yaw turns,
// and loads roll_offset 467 and wrap_threshold 3300; no clearing pass is needed.
module imu_frame_parser_crc16_unit #(
  parameter int unsigned MAX_FRAME_BYTES = imufp_pkg::MAX_FRAME_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_last_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic signed [16:0]  out_yaw_rate,
  output logic signed [16:0]  out_pitch_rate,
  output logic signed [16:0]  out_roll_rate,
  output logic signed [27:0]  out_yaw_att,
  output logic signed [15:0]  out_pitch_att,
  output logic signed [16:0]  out_roll_att,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);

  logic        s1_valid_r;
  logic [7:0]  s1_data_r;
  logic        s1_last_r;
  logic        s1_fire;

  logic [15:0] roll_offset_r;
  logic [11:0] wrap_threshold_r;

  logic                  res_valid;
  logic                  res_ready;
  imufp_pkg::frame_res_t res;

  // a word that ends a frame waits until the result stage has room
  assign s1_fire   = s1_valid_r && (!s1_last_r || res_ready);
  assign in_ready  = !s1_valid_r || s1_fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      roll_offset_r    <= imufp_pkg::ROLL_OFFSET_RST;
      wrap_threshold_r <= imufp_pkg::WRAP_THRESHOLD_RST;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          imufp_pkg::REG_ROLL_OFFSET:    roll_offset_r    <= cfg_data;
          imufp_pkg::REG_WRAP_THRESHOLD: wrap_threshold_r <= cfg_data[11:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  imufp_frame #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (s1_fire),
    .byte_data  (s1_data_r),
    .byte_last  (s1_last_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  imufp_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res_valid),
    .res            (res),
    .res_ready      (res_ready),
    .roll_offset    (roll_offset_r),
    .wrap_threshold (wrap_threshold_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_yaw_rate   (out_yaw_rate),
    .out_pitch_rate (out_pitch_rate),
    .out_roll_rate  (out_roll_rate),
    .out_yaw_att    (out_yaw_att),
    .out_pitch_att  (out_pitch_att),
    .out_roll_att   (out_roll_att)
  );

endmodule

>>> rtl/imufp_checker.sv
// Port-level checker for the IMU frame parser, bound to the top level.
`include "imu_frame_parser_crc16_unit_defines.svh"

module imufp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [1:0]          out_status,
  input logic signed [16:0]  out_yaw_rate,
  input logic signed [16:0]  out_pitch_rate,
  input logic signed [16:0]  out_roll_rate,
  input logic signed [27:0]  out_yaw_att,
  input logic signed [15:0]  out_pitch_att,
  input logic signed [16:0]  out_roll_att
);

  logic         status_known;
  logic         rates_in_range;
  logic         stalled;
  logic [113:0] result_word;

  assign status_known = (out_status == imufp_pkg::ST_OK) ||
                        (out_status == imufp_pkg::ST_BAD_FRAME) ||
                        (out_status == imufp_pkg::ST_BAD_CRC);

  // negated int16 rates stay within -32767..32768
  assign rates_in_range = out_yaw_rate >= -17'sd32767 && out_yaw_rate <= 17'sd32768 &&
                          out_pitch_rate >= -17'sd32767 && out_pitch_rate <= 17'sd32768 &&
                          out_roll_rate >= -17'sd32767 && out_roll_rate <= 17'sd32768;

  assign stalled     = out_valid && !out_ready;
  assign result_word = {out_status, out_yaw_rate, out_pitch_rate, out_roll_rate,
                        out_yaw_att, out_pitch_att, out_roll_att};

  `IMUFP_ASSERT_IMPL(a_status_code, clk, rst_n, out_valid, status_known, "bad status code")

  `IMUFP_ASSERT_IMPL(a_rate_range, clk, rst_n, out_valid, rates_in_range, "rate out of range")

  // a stalled result word stays offered and unchanged
  `IMUFP_ASSERT_CLK(a_out_keep, clk, rst_n, stalled |=> out_valid, "result dropped while stalled")

  `IMUFP_ASSERT_CLK(a_out_hold, clk, rst_n, stalled |=> $stable(result_word), "held word changed")

endmodule

bind imu_frame_parser_crc16_unit imufp_checker u_imufp_checker (.*);
